>>> design/ctnm_pkg.sv
// ----------------------------------------------------------------------------
// ctnm_pkg
// Shared types and constants of the clock table nearest-match unit.
// ----------------------------------------------------------------------------
package ctnm_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam int CODE_W   = 8;
  localparam int FREQ_W   = 20;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // Rounding to a multiple of 500 after adding a bias of 249.
  localparam int ROUND_W = FREQ_W + 1;
  localparam logic [ROUND_W-1:0] ROUND_BIAS = ROUND_W'(249);
  localparam int STEP_W = 9;
  localparam logic [STEP_W-1:0] ROUND_STEP = STEP_W'(500);

  // Division by 500 as a multiply by ceil(2^30 / 500) and a shift by 30.
  // Exact for every dividend below 2^30 / 176, far above the 21-bit range.
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(2147484);
  localparam int PROD_W      = ROUND_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int SCALED_W    = QUOT_W + STEP_W;
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_STORED    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_FULL      = STATUS_W'(2);

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] select_code;
    logic [FREQ_W-1:0] frequency;
  } ctnm_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] add_status;
    logic [CODE_W-1:0]   nearest_code;
    logic [COUNT_W-1:0]  entry_count;
  } ctnm_rsp_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [FREQ_W-1:0] freq;
  } ctnm_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_SCALE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } ctnm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // capture the request beat
    logic round;      // biased frequency times reciprocal
    logic scale;      // quotient times step, start of a scan
    logic scan_read;  // read the entry at the scan index
    logic write;      // append the pending entry
    logic done_load;  // load the response register
  } ctnm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;
    logic full;
    logic scan_end;
    logic dup;
    logic out_free;
  } ctnm_sts_t;

endpackage

>>> design/clock_table_nearest_match_unit.sv
// ----------------------------------------------------------------------------
// clock_table_nearest_match_unit
// The block takes no new request until the response of the last one has
// been loaded into the response register; the scan reads one table entry
// per cycle through the single read port of the entry memory.
// Reset clears the fill count and the handshakes; the table is not cleared.
// ----------------------------------------------------------------------------
module clock_table_nearest_match_unit
  import ctnm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  ctnm_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output ctnm_rsp_t rsp
);

  // The controller only sequences; all storage and arithmetic lives in the
  // datapath. An add first rounds its frequency in two registered steps (a
  // reciprocal multiply for the division by 500, then the multiply back by
  // 500), then scans the filled entries for an equal frequency and appends
  // the entry when none matched. A find goes through the same steps, keeps
  // its frequency unrounded and tracks the nearest entry during the scan;
  // the strict less-than compare keeps the earliest entry on a tie.
  ctnm_cmd_t cmd;
  ctnm_sts_t sts;

  ctnm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The response register lets a finished beat wait on a stalled consumer
  // while the block returns to idle for the next request.
  ctnm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  // An append never happens into a full table.
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !sts.full)
    else $error("entry appended to a full table");

  // An append never stores a frequency the scan found already present.
  a_no_dup_write: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !sts.dup)
    else $error("duplicate frequency appended");

  // A new response never overwrites one that is still being held.
  a_no_rsp_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.done_load |-> (!rsp_valid || !rsp_stall))
    else $error("pending response overwritten");

  // After taking a request beat the block is busy in the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request taken back to back");

endmodule

>>> design/ctnm_ram.sv
// ----------------------------------------------------------------------------
// ctnm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/ctnm_ctrl.sv
// ----------------------------------------------------------------------------
// ctnm_ctrl
// Sequencer of the clock table: round, scan, append and respond.
// ----------------------------------------------------------------------------
module ctnm_ctrl
  import ctnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  ctnm_sts_t sts,
  output ctnm_cmd_t cmd
);

  ctnm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        // A full table rejects an add without looking at the entries.
        if (sts.is_add && sts.full) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // The compare of the last entry read happens in the cycle that sees
        // the end, so no separate drain cycle is needed.
        if (sts.scan_end) begin
          state_next = sts.is_add ? S_WRITE : S_DONE;
        end else begin
          cmd.scan_read = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.write  = !sts.dup;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.done_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/ctnm_dp.sv
// ----------------------------------------------------------------------------
// ctnm_dp
// Datapath of the clock table: rounding, entry memory, scan compare, response.
// ----------------------------------------------------------------------------
module ctnm_dp
  import ctnm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  ctnm_cmd_t cmd,
  output ctnm_sts_t sts,
  input  ctnm_req_t req,
  output ctnm_rsp_t rsp,
  output logic      rsp_valid,
  input  logic      rsp_stall
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(TABLE_DEPTH);

  ctnm_req_t          item;
  logic [QUOT_W-1:0]  quot;
  logic [FREQ_W-1:0]  key;
  logic [CNTW-1:0]    fill;
  logic [CNTW-1:0]    idx;
  logic               rd_valid;
  logic               dup;
  logic               have;
  logic               full_hit;
  logic [FREQ_W-1:0]  near_err;
  logic [CODE_W-1:0]  near_code;

  logic [ROUND_W-1:0]  biased;
  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] scaled;
  logic [FREQ_W-1:0]   rounded;
  logic [FREQ_W-1:0]   err;
  ctnm_entry_t         rd_entry;
  ctnm_entry_t         wr_entry;
  logic [CNTW+COUNT_W-1:0] count_ext;

  assign biased  = ROUND_W'(item.frequency) + ROUND_BIAS;
  assign prod    = PROD_W'(biased) * PROD_W'(RECIP_MUL);
  assign scaled  = SCALED_W'(quot) * SCALED_W'(ROUND_STEP);
  assign rounded = (scaled > SCALED_W'(FREQ_MAX)) ? FREQ_MAX : scaled[FREQ_W-1:0];

  assign err = (key >= rd_entry.freq) ? (key - rd_entry.freq) : (rd_entry.freq - key);

  assign wr_entry.code = item.select_code;
  assign wr_entry.freq = key;

  ctnm_ram #(
    .WIDTH ($bits(ctnm_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (fill[AW-1:0]),
    .wdata (wr_entry),
    .raddr (idx[AW-1:0]),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= req;
    end
    if (cmd.round) begin
      quot <= prod[PROD_W-1:RECIP_SHIFT];
    end
    if (cmd.scale) begin
      key <= (item.kind == KIND_ADD) ? rounded : item.frequency;
    end
  end

  // Scan state: index, read pipeline flag and running match results.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_read;
    end
    if (cmd.scale) begin
      idx       <= '0;
      dup       <= 1'b0;
      have      <= 1'b0;
      full_hit  <= (fill == DEPTH_CNT);
      near_code <= '0;
      near_err  <= '0;
    end else begin
      if (cmd.scan_read) begin
        idx <= idx + CNTW'(1);
      end
      if (rd_valid) begin
        if (rd_entry.freq == key) begin
          dup <= 1'b1;
        end
        if (!have || err < near_err) begin
          have      <= 1'b1;
          near_err  <= err;
          near_code <= rd_entry.code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.write) begin
      fill <= fill + CNTW'(1);
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, fill};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.done_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done_load) begin
      if (item.kind == KIND_ADD) begin
        rsp.add_status   <= full_hit ? STATUS_FULL : (dup ? STATUS_DUPLICATE : STATUS_STORED);
        rsp.nearest_code <= '0;
      end else begin
        rsp.add_status   <= STATUS_STORED;
        rsp.nearest_code <= near_code;
      end
      rsp.entry_count <= count_ext[COUNT_W-1:0];
    end
  end

  assign sts.is_add   = (item.kind == KIND_ADD);
  assign sts.full     = (fill == DEPTH_CNT);
  assign sts.scan_end = (idx == fill);
  assign sts.dup      = dup;
  assign sts.out_free = !rsp_valid || !rsp_stall;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the clock table nearest-match unit against a predictor of its own.
// Adds round to 500 kHz steps, are dropped on duplicates or once the table
// holds 64 entries, and finds return the nearest entry's code. The stimulus
// begins with a fixed sequence of corner cases, then adds and finds built to
// hit duplicates, rounding boundaries, ties and the full table. Both sides of
// the handshake idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import ctnm_pkg::*;

  localparam int unsigned ROUND_STEP_KHZ = 500;
  localparam int unsigned ROUND_BIAS_KHZ = 249;
  localparam int unsigned FREQ_TOP       = (1 << FREQ_W) - 1;
  localparam int          RANDOM_BEATS   = 550;
  // The slowest beat scans 64 entries. Waiting longer than such a beat
  // takes at the end catches any stray response.
  localparam int          DRAIN_CYCLES   = 100;
  localparam int          REPORT_LIMIT   = 10;

  // Scoreboard: mirrors the entry table, predicts one response per accepted
  // request and checks the responses in order.
  class clock_table_scoreboard;
    logic [CODE_W-1:0] codes[TABLE_DEPTH_DEFAULT];
    logic [FREQ_W-1:0] freqs[TABLE_DEPTH_DEFAULT];
    int unsigned       stored;
    ctnm_rsp_t         awaited[$];
    int unsigned       failures;

    function new();
      stored   = 0;
      failures = 0;
    endfunction

    // Applies one request beat to the mirrored table and queues the
    // response that it must produce.
    function void note_request(ctnm_req_t r);
      ctnm_rsp_t   outcome;
      int unsigned rounded;
      int unsigned err;
      int unsigned min_err;
      bit          found;
      outcome = '0;
      found   = 1'b0;
      min_err = 0;
      if (r.kind == KIND_ADD) begin
        if (stored >= TABLE_DEPTH_DEFAULT) begin
          outcome.add_status = STATUS_FULL;
        end else begin
          rounded = ((int'(r.frequency) + ROUND_BIAS_KHZ) / ROUND_STEP_KHZ) * ROUND_STEP_KHZ;
          if (rounded > FREQ_TOP) rounded = FREQ_TOP;
          for (int i = 0; i < stored; i++) begin
            if (freqs[i] == rounded) found = 1'b1;
          end
          if (found) begin
            outcome.add_status = STATUS_DUPLICATE;
          end else begin
            codes[stored] = r.select_code;
            freqs[stored] = FREQ_W'(rounded);
            stored++;
            outcome.add_status = STATUS_STORED;
          end
        end
      end else begin
        for (int i = 0; i < stored; i++) begin
          err = (r.frequency > freqs[i]) ? r.frequency - freqs[i] : freqs[i] - r.frequency;
          if (!found || err < min_err) begin
            found                = 1'b1;
            min_err              = err;
            outcome.nearest_code = codes[i];
          end
        end
      end
      outcome.entry_count = COUNT_W'(stored);
      awaited.push_back(outcome);
    endfunction

    function void check_result(ctnm_rsp_t got);
      ctnm_rsp_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected response: status=%0d code=%0d count=%0d",
                   got.add_status, got.nearest_code, got.entry_count);
        return;
      end
      want = awaited.pop_front();
      if (got.add_status !== want.add_status || got.nearest_code !== want.nearest_code ||
          got.entry_count !== want.entry_count) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display({"response mismatch: expected status=%0d code=%0d count=%0d,",
                    " got status=%0d code=%0d count=%0d"},
                   want.add_status, want.nearest_code, want.entry_count,
                   got.add_status, got.nearest_code, got.entry_count);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  ctnm_req_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  ctnm_rsp_t rsp;

  clock_table_scoreboard board;

  clock_table_nearest_match_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every response beat is checked at the rising edge where it is taken.
  // The stall seen here was driven at the previous falling edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_result(rsp);
  end

  // Receiver back-pressure. The pattern switches between phases of no stall,
  // coin-flip stalls and a fixed periodic stall, each phase of random length,
  // so that stalls land on every point of the unit's work.
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;
  stall_mode_t stall_mode       = STALL_NONE;
  int unsigned stall_phase_left = 0;
  int unsigned stall_tick       = 0;

  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       = stall_mode_t'($urandom_range(0, 2));
      stall_phase_left = $urandom_range(20, 300);
    end else begin
      stall_phase_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     rsp_stall <= 1'b0;
      STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 1) == 0);
      STALL_PERIODIC: rsp_stall <= ((stall_tick % 9) < 5);
      default:        rsp_stall <= 1'b0;
    endcase
  end

  // Presents one request beat and waits for it to be taken. Valid is left
  // high afterwards, so a following beat goes out without a bubble; a gap is
  // only made by hold_off.
  task automatic send_request(input logic kind, input int unsigned code,
                              input int unsigned freq);
    ctnm_req_t item;
    item.kind        = kind;
    item.select_code = CODE_W'(code);
    item.frequency   = FREQ_W'(freq);
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(item);
  endtask

  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  // Picks a frequency for a random beat. Adds aim at fresh values, values
  // that round onto a stored entry, and the point where rounding flips to
  // the next step. Finds aim near stored entries and at the exact midpoint
  // of two entries, where the lower index has to win the tie.
  function automatic int unsigned pick_frequency(input logic kind);
    int          pick;
    int          base;
    int          other;
    int          f;
    pick = $urandom_range(0, 9);
    f    = $urandom_range(0, FREQ_TOP);
    if (pick >= 4 && pick <= 6 && board.stored > 0) begin
      base = board.freqs[$urandom_range(0, board.stored - 1)];
      if (kind == KIND_ADD) f = base + $urandom_range(0, 499) - 249;
      else                  f = base + $urandom_range(0, 2000) - 1000;
    end else if (pick >= 7 && pick <= 8) begin
      if (kind == KIND_ADD || board.stored < 2) begin
        f = $urandom_range(0, 2097) * ROUND_STEP_KHZ + 250 + $urandom_range(0, 1);
      end else begin
        base  = board.freqs[$urandom_range(0, board.stored - 1)];
        other = board.freqs[$urandom_range(0, board.stored - 1)];
        f     = (base + other) / 2;
      end
    end else if (pick == 9) begin
      f = $urandom_range(0, 1) ? FREQ_TOP : 0;
    end
    if (f < 0) f = 0;
    if (f > FREQ_TOP) f = FREQ_TOP;
    return f;
  endfunction

  initial begin
    logic        kind;
    int unsigned burst_left;
    board      = new();
    burst_left = 0;

    // Synchronous reset, held at the start and released at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats. A find on the empty table must answer code 0.
    send_request(KIND_FIND, 8'h5A, 20'h12345);
    // Field extremes: the lowest and highest frequency and code. The top
    // frequency rounds down to 1048500.
    send_request(KIND_ADD, 0, 0);
    send_request(KIND_ADD, 255, FREQ_TOP);
    send_request(KIND_ADD, 17, FREQ_TOP - 74);      // rounds onto the top entry
    // 249 still rounds to zero, 250 to zero as well, 251 up to 500.
    send_request(KIND_ADD, 3, 249);
    send_request(KIND_ADD, 4, 250);
    send_request(KIND_ADD, 5, 251);
    send_request(KIND_ADD, 6, 1000);
    send_request(KIND_ADD, 7, 2000);
    send_request(KIND_ADD, 8, 1750);                // rounds to 1500
    send_request(KIND_ADD, 9, 1751);                // rounds to 2000, duplicate
    // Ties: 1250 is equally far from 1000 and 1500, 750 from 500 and 1000.
    send_request(KIND_FIND, 0, 1250);
    send_request(KIND_FIND, 0, 750);
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_FIND, 255, FREQ_TOP);
    send_request(KIND_FIND, 0, 525250);             // halfway between 2000 and top
    send_request(KIND_FIND, 0, 1048499);

    // Random beats in bursts with gaps. Adds dominate until the table is
    // full, after which most beats are finds and the adds hit the full case.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (burst_left == 0) begin
        hold_off($urandom_range(1, 15));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 10);
      end
      burst_left--;
      if (board.stored < TABLE_DEPTH_DEFAULT)
        kind = ($urandom_range(0, 9) < 6) ? KIND_ADD : KIND_FIND;
      else
        kind = ($urandom_range(0, 3) == 0) ? KIND_ADD : KIND_FIND;
      send_request(kind, $urandom_range(0, 255), pick_frequency(kind));
    end

    @(negedge clk);
    req_valid <= 1'b0;

    // Let every queued response arrive, then watch a while for extras.
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.failures == 0 && board.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog. Ends a run that hangs with a failure.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
design/ctnm_pkg.sv
design/ctnm_ram.sv
design/ctnm_ctrl.sv
design/ctnm_dp.sv
design/clock_table_nearest_match_unit.sv
test/tb_top.sv
